// File: src/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg: shared types and constants for the bicubic resizer
// Widths, register indexes, payload structs and state encodings.
// ----------------------------------------------------------------------------
package bir_pkg;

    // image store geometry (power of two sizes)
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 12;

    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = X_W + Y_W;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;

    // register and field widths
    localparam int SRC_W  = 9;
    localparam int DST_W  = 13;
    localparam int DEST_W = 12;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // coordinate divider
    localparam int DIV_NUM_W = SRC_W + DEST_W + FRAC_BITS;
    localparam int DIV_DEN_W = DST_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
    localparam int INT_W     = DIV_NUM_W - FRAC_BITS;

    // cubic evaluator
    localparam int SAMP_W = 16;
    localparam int COEF_W = SAMP_W + 4;
    localparam int ACC_W  = 56;
    localparam int LO_W   = 24;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int PLO_W  = LO_W + FRAC_BITS;

    // register indexes
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // reset values
    localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = SRC_W'(256);
    localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = SRC_W'(256);
    localparam logic [DST_W-1:0] DST_WIDTH_RST  = DST_W'(512);
    localparam logic [DST_W-1:0] DST_HEIGHT_RST = DST_W'(512);

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [7:0]        write_x;
        logic [7:0]        write_y;
        logic [CH_W-1:0]   in_red;
        logic [CH_W-1:0]   in_green;
        logic [CH_W-1:0]   in_blue;
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
    } out_item_t;

    // handshake between sequencer and an arithmetic unit
    typedef struct packed {
        logic start;
        logic done;
    } unit_ctl_t;

    typedef logic [3:0][SAMP_W-1:0] quad_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVX,
        ST_WAITX,
        ST_DIVY,
        ST_WAITY,
        ST_READ,
        ST_VCUB,
        ST_VWAIT,
        ST_HCUB,
        ST_HWAIT,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [2:0] {
        CB_IDLE,
        CB_MLO,
        CB_MHI,
        CB_ADD,
        CB_DONE
    } cub_state_t;

endpackage

// File: src/bicubic_image_resize.sv
// ----------------------------------------------------------------------------
// bicubic_image_resize: bicubic scaler over a stored source image
// Pixel writes go to a single port image ram; sample requests map the
// destination coordinate, read a 4x4 window and run two cubic passes.
// ----------------------------------------------------------------------------
//  channel   signals                              beat
//  request   start, busy, request                 start && !busy
//  result    strobe, result                       strobe, one cycle
//  config    psel penable pwrite paddr pwdata     psel && penable && pwrite
//            prdata pready
//
// A pixel write never raises busy.
// A sample keeps busy high through two coordinate divisions on one shared
// divider, then four columns of ram reads (single port) each followed by a
// cubic, then one horizontal cubic and the result cycle.
// The three channels run on three cubic units in lockstep.
// Reset clears control and config; the image ram holds no reset value.
// The result is shown for one cycle with strobe; it cannot be held off.
// ----------------------------------------------------------------------------
module bicubic_image_resize (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bir_pkg::in_item_t             request,
    output logic                          strobe,
    output bir_pkg::out_item_t            result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bir_pkg::PADDR_W-1:0]   paddr,
    input  logic [bir_pkg::PDATA_W-1:0]   pwdata,
    output logic [bir_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    bir_pkg::ctl_state_t state_reg, state_next;

    logic [bir_pkg::SRC_W-1:0]  src_w_reg, src_h_reg;
    logic [bir_pkg::DST_W-1:0]  dst_w_reg, dst_h_reg;
    logic                       cfg_we;
    logic [1:0]                 cfg_idx;

    logic [bir_pkg::DEST_W-1:0]    dx_reg, dy_reg;
    logic [bir_pkg::INT_W-1:0]     ix_reg, iy_reg;
    logic [bir_pkg::FRAC_BITS-1:0] mux_reg, muy_reg;
    logic [1:0]                    i_reg, i_next;
    logic [2:0]                    j_reg, j_next;
    logic [bir_pkg::CH_W-1:0]      samp_reg [3][4];
    logic signed [bir_pkg::SAMP_W-1:0] col_reg [3][4];

    logic                            accept;
    logic                            ram_we;
    logic [bir_pkg::ADDR_W-1:0]      ram_addr;
    logic [bir_pkg::PIX_W-1:0]       ram_wdata, ram_rdata;
    logic [bir_pkg::SRC_W-1:0]       cx, cy;

    bir_pkg::unit_ctl_t              div_ctl;
    logic                            div_done;
    logic [bir_pkg::DIV_NUM_W-1:0]   div_numer, div_quot;
    logic [bir_pkg::DIV_DEN_W-1:0]   div_denom;
    logic [bir_pkg::SRC_W+bir_pkg::DEST_W-1:0] span;

    logic                            cub_start;
    logic [2:0]                      cub_done;
    logic                            cub_all_done;
    bir_pkg::quad_t                  cub_y [3];
    logic [bir_pkg::FRAC_BITS-1:0]   cub_mu;
    logic signed [bir_pkg::SAMP_W-1:0] cub_res [3];
    logic [bir_pkg::CH_W-1:0]        chan [3];

    // edge clamped source coordinate base-1+off
    function automatic logic [bir_pkg::SRC_W-1:0] edge_pos(
        input logic [bir_pkg::INT_W-1:0] base,
        input logic [1:0]                off,
        input logic [bir_pkg::SRC_W-1:0] size
    );
        logic signed [bir_pkg::INT_W+1:0] p;
        logic signed [bir_pkg::INT_W+1:0] lim;
        p   = $signed({2'b00, base}) + $signed({{bir_pkg::INT_W{1'b0}}, off})
            - $signed((bir_pkg::INT_W+2)'(1));
        lim = $signed({{(bir_pkg::INT_W+2-bir_pkg::SRC_W){1'b0}}, size});
        if (p < 0)
        begin
            return '0;
        end
        else if (p >= lim)
        begin
            return size - 1'b1;
        end
        return p[bir_pkg::SRC_W-1:0];
    endfunction

    // config port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_comb
    begin
        unique case (cfg_idx)
            bir_pkg::REG_SRC_WIDTH:  prdata = bir_pkg::PDATA_W'(src_w_reg);
            bir_pkg::REG_SRC_HEIGHT: prdata = bir_pkg::PDATA_W'(src_h_reg);
            bir_pkg::REG_DST_WIDTH:  prdata = bir_pkg::PDATA_W'(dst_w_reg);
            default:                 prdata = bir_pkg::PDATA_W'(dst_h_reg);
        endcase
    end

    // size registers, zero acts as one, source capped at the store size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= bir_pkg::SRC_WIDTH_RST;
            src_h_reg <= bir_pkg::SRC_HEIGHT_RST;
            dst_w_reg <= bir_pkg::DST_WIDTH_RST;
            dst_h_reg <= bir_pkg::DST_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                bir_pkg::REG_SRC_WIDTH:
                begin
                    if (pwdata[bir_pkg::SRC_W-1:0] == '0)
                        src_w_reg <= bir_pkg::SRC_W'(1);
                    else if (32'(pwdata[bir_pkg::SRC_W-1:0]) > bir_pkg::MAX_WIDTH)
                        src_w_reg <= bir_pkg::SRC_W'(bir_pkg::MAX_WIDTH);
                    else
                        src_w_reg <= pwdata[bir_pkg::SRC_W-1:0];
                end
                bir_pkg::REG_SRC_HEIGHT:
                begin
                    if (pwdata[bir_pkg::SRC_W-1:0] == '0)
                        src_h_reg <= bir_pkg::SRC_W'(1);
                    else if (32'(pwdata[bir_pkg::SRC_W-1:0]) > bir_pkg::MAX_HEIGHT)
                        src_h_reg <= bir_pkg::SRC_W'(bir_pkg::MAX_HEIGHT);
                    else
                        src_h_reg <= pwdata[bir_pkg::SRC_W-1:0];
                end
                bir_pkg::REG_DST_WIDTH:
                begin
                    if (pwdata[bir_pkg::DST_W-1:0] == '0)
                        dst_w_reg <= bir_pkg::DST_W'(1);
                    else
                        dst_w_reg <= pwdata[bir_pkg::DST_W-1:0];
                end
                default:
                begin
                    if (pwdata[bir_pkg::DST_W-1:0] == '0)
                        dst_h_reg <= bir_pkg::DST_W'(1);
                    else
                        dst_h_reg <= pwdata[bir_pkg::DST_W-1:0];
                end
            endcase
        end
    end

    assign accept = start && !busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            bir_pkg::ST_IDLE:
            begin
                if (accept && request.cmd == bir_pkg::CMD_SAMPLE)
                    state_next = bir_pkg::ST_DIVX;
            end
            bir_pkg::ST_DIVX: state_next = bir_pkg::ST_WAITX;
            bir_pkg::ST_WAITX:
            begin
                if (div_ctl.done)
                    state_next = bir_pkg::ST_DIVY;
            end
            bir_pkg::ST_DIVY: state_next = bir_pkg::ST_WAITY;
            bir_pkg::ST_WAITY:
            begin
                if (div_ctl.done)
                begin
                    state_next = bir_pkg::ST_READ;
                    i_next     = 2'd0;
                    j_next     = 3'd0;
                end
            end
            bir_pkg::ST_READ:
            begin
                if (j_reg == 3'd4)
                begin
                    state_next = bir_pkg::ST_VCUB;
                    j_next     = 3'd0;
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                end
            end
            bir_pkg::ST_VCUB: state_next = bir_pkg::ST_VWAIT;
            bir_pkg::ST_VWAIT:
            begin
                if (cub_all_done)
                begin
                    if (i_reg == 2'd3)
                    begin
                        state_next = bir_pkg::ST_HCUB;
                    end
                    else
                    begin
                        state_next = bir_pkg::ST_READ;
                        i_next     = i_reg + 2'd1;
                    end
                end
            end
            bir_pkg::ST_HCUB: state_next = bir_pkg::ST_HWAIT;
            bir_pkg::ST_HWAIT:
            begin
                if (cub_all_done)
                    state_next = bir_pkg::ST_OUT;
            end
            bir_pkg::ST_OUT: state_next = bir_pkg::ST_IDLE;
            default: state_next = bir_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy          = (state_reg != bir_pkg::ST_IDLE);
        strobe        = (state_reg == bir_pkg::ST_OUT);
        div_ctl.start = (state_reg == bir_pkg::ST_DIVX) || (state_reg == bir_pkg::ST_DIVY);
        div_ctl.done  = div_done;
        cub_start     = (state_reg == bir_pkg::ST_VCUB) || (state_reg == bir_pkg::ST_HCUB);
        ram_we        = accept && request.cmd == bir_pkg::CMD_WRITE
                     && 32'(request.write_x) < bir_pkg::MAX_WIDTH
                     && 32'(request.write_y) < bir_pkg::MAX_HEIGHT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bir_pkg::ST_IDLE;
            i_reg     <= 2'd0;
            j_reg     <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    // image ram address and data
    always_comb
    begin
        cx = edge_pos(ix_reg, i_reg, src_w_reg);
        cy = edge_pos(iy_reg, j_reg[1:0], src_h_reg);
        ram_wdata = {request.in_red, request.in_green, request.in_blue};
        if (state_reg == bir_pkg::ST_READ)
            ram_addr = {cy[bir_pkg::Y_W-1:0], cx[bir_pkg::X_W-1:0]};
        else
            ram_addr = {request.write_y[bir_pkg::Y_W-1:0], request.write_x[bir_pkg::X_W-1:0]};
    end

    bir_ram #(
        .WIDTH (bir_pkg::PIX_W),
        .DEPTH (bir_pkg::DEPTH)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // coordinate mapping: size*dest << frac / dest size
    always_comb
    begin
        if (state_reg == bir_pkg::ST_DIVY)
        begin
            span      = src_h_reg * dy_reg;
            div_denom = dst_h_reg;
        end
        else
        begin
            span      = src_w_reg * dx_reg;
            div_denom = dst_w_reg;
        end
        div_numer = {span, {bir_pkg::FRAC_BITS{1'b0}}};
    end

    bir_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_ctl.start),
        .numer (div_numer),
        .denom (div_denom),
        .quot  (div_quot),
        .done  (div_done)
    );

    // cubic operands: window samples, then column results
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (state_reg == bir_pkg::ST_HCUB)
                    cub_y[c][k] = col_reg[c][k];
                else
                    cub_y[c][k] = {{(bir_pkg::SAMP_W-bir_pkg::CH_W){1'b0}}, samp_reg[c][k]};
            end
        end
        cub_mu = (state_reg == bir_pkg::ST_HCUB) ? mux_reg : muy_reg;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_cub
        bir_cubic u_cubic (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cub_start),
            .y     (cub_y[g]),
            .mu    (cub_mu),
            .res   (cub_res[g]),
            .done  (cub_done[g])
        );
    end

    assign cub_all_done = &cub_done;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && request.cmd == bir_pkg::CMD_SAMPLE)
        begin
            dx_reg <= request.dest_x;
            dy_reg <= request.dest_y;
        end
        if (state_reg == bir_pkg::ST_WAITX && div_ctl.done)
        begin
            ix_reg  <= div_quot[bir_pkg::DIV_NUM_W-1:bir_pkg::FRAC_BITS];
            mux_reg <= div_quot[bir_pkg::FRAC_BITS-1:0];
        end
        if (state_reg == bir_pkg::ST_WAITY && div_ctl.done)
        begin
            iy_reg  <= div_quot[bir_pkg::DIV_NUM_W-1:bir_pkg::FRAC_BITS];
            muy_reg <= div_quot[bir_pkg::FRAC_BITS-1:0];
        end
        // read data from the registered ram lands the cycle after its address
        if (state_reg == bir_pkg::ST_READ && j_reg != 3'd0)
        begin
            for (int c = 0; c < 3; c++)
            begin
                samp_reg[c][2'(j_reg - 3'd1)] <= ram_rdata[bir_pkg::PIX_W-1-bir_pkg::CH_W*c -:
                                                           bir_pkg::CH_W];
            end
        end
        if (state_reg == bir_pkg::ST_VWAIT && cub_all_done)
        begin
            for (int c = 0; c < 3; c++)
            begin
                col_reg[c][i_reg] <= cub_res[c];
            end
        end
    end

    // channel clamp to 0..255
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (cub_res[c] < 0)
                chan[c] = '0;
            else if (cub_res[c] > $signed(bir_pkg::SAMP_W'(255)))
                chan[c] = '1;
            else
                chan[c] = cub_res[c][bir_pkg::CH_W-1:0];
        end
        result.out_red   = chan[0];
        result.out_green = chan[1];
        result.out_blue  = chan[2];
    end

`ifndef SYNTHESIS
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !busy)
        else $error("ram write while a sample is in flight");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && request.cmd == bir_pkg::CMD_SAMPLE))
        else $error("busy raised without a sample request");

    a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !busy && !strobe)
        else $error("result beat not followed by idle");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.done |-> (state_reg == bir_pkg::ST_WAITX || state_reg == bir_pkg::ST_WAITY))
        else $error("divider done outside a wait state");

    a_cub_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        cub_done[0] |-> cub_done[1] && cub_done[2])
        else $error("cubic units out of step");
`endif

endmodule

// File: src/bir_ram.sv
// ----------------------------------------------------------------------------
// bir_ram: generic single port ram
// One access per cycle, read data registered.
// ----------------------------------------------------------------------------
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: src/bir_div.sv
// ----------------------------------------------------------------------------
// bir_div: restoring divider
// Unsigned quotient, one bit per cycle, done pulses one cycle at the end.
// ----------------------------------------------------------------------------
module bir_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bir_pkg::DIV_NUM_W-1:0]  numer,
    input  logic [bir_pkg::DIV_DEN_W-1:0]  denom,
    output logic [bir_pkg::DIV_NUM_W-1:0]  quot,
    output logic                           done
);

    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic [bir_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bir_pkg::DIV_NUM_W-1:0]  num_reg, num_next;
    logic [bir_pkg::DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [bir_pkg::DIV_DEN_W-1:0]  den_reg, den_next;
    logic [bir_pkg::DIV_DEN_W:0]    rem_sh;
    logic                           qbit;

    // one restoring step
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[bir_pkg::DIV_NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = bir_pkg::DIV_CNT_W'(bir_pkg::DIV_NUM_W);
            num_next = numer;
            rem_next = '0;
            den_next = denom;
        end
        else if (run_reg)
        begin
            num_next = {num_reg[bir_pkg::DIV_NUM_W-2:0], qbit};
            if (qbit)
            begin
                rem_next = bir_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_next = rem_sh[bir_pkg::DIV_DEN_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == bir_pkg::DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = num_reg;
    assign done = done_reg;

endmodule

// File: src/bir_cubic.sv
// ----------------------------------------------------------------------------
// bir_cubic: four point cubic evaluator
// Horner form a0*mu^3+a1*mu^2+a2*mu+a3 with exact fixed point, one split
// multiplier, result truncated toward zero.
// ----------------------------------------------------------------------------
module bir_cubic (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  bir_pkg::quad_t                      y,
    input  logic [bir_pkg::FRAC_BITS-1:0]       mu,
    output logic signed [bir_pkg::SAMP_W-1:0]   res,
    output logic                                done
);

    bir_pkg::cub_state_t state_reg, state_next;
    logic [1:0]                          step_reg, step_next;
    logic signed [bir_pkg::COEF_W-1:0]   a1_reg, a2_reg, a3_reg;
    logic signed [bir_pkg::ACC_W-1:0]    t_reg, t_next;
    logic [bir_pkg::PLO_W-1:0]           plo_reg, plo_next;
    logic [bir_pkg::FRAC_BITS-1:0]       mu_reg;

    logic signed [bir_pkg::COEF_W-1:0]   y0, y1, y2, y3, a0, a1, a2, a3;
    logic signed [bir_pkg::HI_W-1:0]     hi;
    logic signed [bir_pkg::HI_W+bir_pkg::FRAC_BITS:0] prod_hi;
    logic signed [bir_pkg::ACC_W-1:0]    term;
    logic signed [bir_pkg::ACC_W-1:0]    quo;
    logic                                fix;

    // coefficients from the four samples
    always_comb
    begin
        y0 = bir_pkg::COEF_W'($signed(y[0]));
        y1 = bir_pkg::COEF_W'($signed(y[1]));
        y2 = bir_pkg::COEF_W'($signed(y[2]));
        y3 = bir_pkg::COEF_W'($signed(y[3]));
        a0 = y3 - y2 - y0 + y1;
        a1 = y0 - y1 - a0;
        a2 = y2 - y0;
        a3 = y1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            bir_pkg::CB_IDLE:
            begin
                if (start)
                begin
                    state_next = bir_pkg::CB_MLO;
                    step_next  = 2'd0;
                end
            end
            bir_pkg::CB_MLO: state_next = bir_pkg::CB_MHI;
            bir_pkg::CB_MHI: state_next = bir_pkg::CB_ADD;
            bir_pkg::CB_ADD:
            begin
                if (step_reg == 2'd2)
                begin
                    state_next = bir_pkg::CB_DONE;
                end
                else
                begin
                    state_next = bir_pkg::CB_MLO;
                    step_next  = step_reg + 2'd1;
                end
            end
            bir_pkg::CB_DONE: state_next = bir_pkg::CB_IDLE;
            default: state_next = bir_pkg::CB_IDLE;
        endcase
    end

    // split multiply and accumulate
    always_comb
    begin
        hi       = t_reg[bir_pkg::ACC_W-1:bir_pkg::LO_W];
        prod_hi  = hi * $signed({1'b0, mu_reg});
        plo_next = plo_reg;
        t_next   = t_reg;
        unique case (step_reg)
            2'd0:    term = bir_pkg::ACC_W'(a1_reg) <<< bir_pkg::FRAC_BITS;
            2'd1:    term = bir_pkg::ACC_W'(a2_reg) <<< (2 * bir_pkg::FRAC_BITS);
            default: term = bir_pkg::ACC_W'(a3_reg) <<< (3 * bir_pkg::FRAC_BITS);
        endcase
        unique case (state_reg)
            bir_pkg::CB_IDLE:
            begin
                if (start)
                begin
                    t_next = bir_pkg::ACC_W'(a0);
                end
            end
            bir_pkg::CB_MLO:
            begin
                plo_next = t_reg[bir_pkg::LO_W-1:0] * mu_reg;
            end
            bir_pkg::CB_MHI:
            begin
                t_next = (bir_pkg::ACC_W'(prod_hi) <<< bir_pkg::LO_W)
                       + $signed({{(bir_pkg::ACC_W-bir_pkg::PLO_W){1'b0}}, plo_reg});
            end
            bir_pkg::CB_ADD:
            begin
                t_next = t_reg + term;
            end
            default:
            begin
                t_next = t_reg;
            end
        endcase
    end

    // truncate toward zero
    always_comb
    begin
        quo  = t_reg >>> (3 * bir_pkg::FRAC_BITS);
        fix  = t_reg[bir_pkg::ACC_W-1] && (|t_reg[3*bir_pkg::FRAC_BITS-1:0]);
        res  = bir_pkg::SAMP_W'(quo + bir_pkg::ACC_W'(fix));
        done = (state_reg == bir_pkg::CB_DONE);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bir_pkg::CB_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        plo_reg <= plo_next;
        if (state_reg == bir_pkg::CB_IDLE && start)
        begin
            a1_reg <= a1;
            a2_reg <= a2;
            a3_reg <= a3;
            mu_reg <= mu;
        end
    end

endmodule

// File: dv/bicubic_image_resize_tb.sv
// ----------------------------------------------------------------------------
// bicubic_image_resize_tb: self-checking bench for the bicubic resizer
// Loads small source images pixel by pixel over the request port, asks for
// scaled pixels under several size settings (extremes included), and checks
// every result beat against a bit-exact fixed-point bicubic predictor.
// ----------------------------------------------------------------------------
module bicubic_image_resize_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef int addr_q_t[$];

    // scoreboard: mirror of the image store, sizes and pending pixels
    class pixel_scoreboard;
        logic [bir_pkg::PIX_W-1:0] image_mirror[bir_pkg::DEPTH];
        bit                        written[bir_pkg::DEPTH];
        int                        sw;
        int                        sh;
        int                        dw;
        int                        dh;
        bir_pkg::out_item_t        pending_pixels[$];
        int                        errors;

        function new();
            sw = 256;
            sh = 256;
            dw = 512;
            dh = 512;
            errors = 0;
        endfunction

        // register update with zero-as-one and upper limit
        function void set_size(logic [1:0] idx, int unsigned value);
            int unsigned v;
            case (idx)
                bir_pkg::REG_SRC_WIDTH, bir_pkg::REG_SRC_HEIGHT: v = value & 32'h1FF;
                default:                                         v = value & 32'h1FFF;
            endcase
            if (v == 0) v = 1;
            case (idx)
                bir_pkg::REG_SRC_WIDTH:
                    sw = (v > bir_pkg::MAX_WIDTH) ? bir_pkg::MAX_WIDTH : v;
                bir_pkg::REG_SRC_HEIGHT:
                    sh = (v > bir_pkg::MAX_HEIGHT) ? bir_pkg::MAX_HEIGHT : v;
                bir_pkg::REG_DST_WIDTH:  dw = v;
                default:                 dh = v;
            endcase
        endfunction

        // fixed-point source position of a destination coordinate
        function longint unsigned map_coord(int src, int dst, logic [bir_pkg::DEST_W-1:0] d);
            longint unsigned num;
            num = (longint'(src) * longint'(d)) << bir_pkg::FRAC_BITS;
            return num / longint'(dst);
        endfunction

        function int edge_fix(int v, int last);
            if (v < 0) return 0;
            if (v > last) return last;
            return v;
        endfunction

        // store addresses of the 4x4 window not yet written
        function addr_q_t missing(logic [bir_pkg::DEST_W-1:0] dx,
                                  logic [bir_pkg::DEST_W-1:0] dy);
            addr_q_t q;
            int ix;
            int iy;
            int a;
            ix = int'(map_coord(sw, dw, dx) >> bir_pkg::FRAC_BITS);
            iy = int'(map_coord(sh, dh, dy) >> bir_pkg::FRAC_BITS);
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    a = edge_fix(iy - 1 + j, sh - 1) * bir_pkg::MAX_WIDTH
                        + edge_fix(ix - 1 + i, sw - 1);
                    if (!written[a]) q.push_back(a);
                end
            end
            return q;
        endfunction

        // exact cubic computed at scale 2^(3*FRAC_BITS), then truncated toward zero
        function longint cubic(longint y0, longint y1, longint y2, longint y3, longint mu);
            longint a0;
            longint a1;
            longint a2;
            longint one;
            longint acc;
            a0  = y3 - y2 - y0 + y1;
            a1  = y0 - y1 - a0;
            a2  = y2 - y0;
            one = longint'(1) << bir_pkg::FRAC_BITS;
            acc = a0 * mu;
            acc = (acc + a1 * one) * mu;
            acc = (acc + a2 * one * one) * mu;
            acc = acc + y1 * one * one * one;
            return acc / (one * one * one);
        endfunction

        // accepted request beat: update the store or predict a pixel
        function void note_beat(bir_pkg::in_item_t it);
            longint unsigned px;
            longint unsigned py;
            int        ix;
            int        iy;
            longint    mux;
            longint    muy;
            longint    s[4];
            longint    col[4];
            longint    v;
            int        a;
            bir_pkg::out_item_t exp_pix;
            logic [bir_pkg::PIX_W-1:0] pix;
            if (it.cmd == bir_pkg::CMD_WRITE)
            begin
                a = int'({it.write_y, it.write_x});
                image_mirror[a] = {it.in_red, it.in_green, it.in_blue};
                written[a] = 1'b1;
                return;
            end
            px  = map_coord(sw, dw, it.dest_x);
            py  = map_coord(sh, dh, it.dest_y);
            ix  = int'(px >> bir_pkg::FRAC_BITS);
            iy  = int'(py >> bir_pkg::FRAC_BITS);
            mux = longint'(px & ((64'd1 << bir_pkg::FRAC_BITS) - 1));
            muy = longint'(py & ((64'd1 << bir_pkg::FRAC_BITS) - 1));
            for (int ch = 0; ch < 3; ch++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        a = edge_fix(iy - 1 + j, sh - 1) * bir_pkg::MAX_WIDTH
                            + edge_fix(ix - 1 + i, sw - 1);
                        pix = image_mirror[a];
                        s[j] = longint'(pix[bir_pkg::PIX_W-1-bir_pkg::CH_W*ch -: bir_pkg::CH_W]);
                    end
                    col[i] = cubic(s[0], s[1], s[2], s[3], muy);
                end
                v = cubic(col[0], col[1], col[2], col[3], mux);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                case (ch)
                    0:       exp_pix.out_red   = bir_pkg::CH_W'(v);
                    1:       exp_pix.out_green = bir_pkg::CH_W'(v);
                    default: exp_pix.out_blue  = bir_pkg::CH_W'(v);
                endcase
            end
            pending_pixels.push_back(exp_pix);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // result beat against the oldest predicted pixel
        task check_beat(bir_pkg::out_item_t got);
            bir_pkg::out_item_t exp_pix;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel %h", got));
                return;
            end
            exp_pix = pending_pixels.pop_front();
            if (got.out_red !== exp_pix.out_red)
                report($sformatf("red %0d, want %0d", got.out_red, exp_pix.out_red));
            if (got.out_green !== exp_pix.out_green)
                report($sformatf("green %0d, want %0d", got.out_green, exp_pix.out_green));
            if (got.out_blue !== exp_pix.out_blue)
                report($sformatf("blue %0d, want %0d", got.out_blue, exp_pix.out_blue));
        endtask
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    bir_pkg::in_item_t           request;
    logic                        strobe;
    bir_pkg::out_item_t          result;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [bir_pkg::PADDR_W-1:0] paddr;
    logic [bir_pkg::PDATA_W-1:0] pwdata;
    logic [bir_pkg::PDATA_W-1:0] prdata;
    logic                        pready;

    pixel_scoreboard sb;
    bit              no_gaps;

    bicubic_image_resize uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result beats are sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && strobe) sb.check_beat(result);
    end

    function int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function logic [bir_pkg::CH_W-1:0] pick_channel();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return bir_pkg::CH_W'($urandom);
    endfunction

    function bir_pkg::in_item_t pixel_write(int x, int y);
        bir_pkg::in_item_t it;
        it          = bir_pkg::in_item_t'({$urandom, $urandom, $urandom});
        it.cmd      = bir_pkg::CMD_WRITE;
        it.write_x  = 8'(x);
        it.write_y  = 8'(y);
        it.in_red   = pick_channel();
        it.in_green = pick_channel();
        it.in_blue  = pick_channel();
        return it;
    endfunction

    // one request beat; returns after the accepting edge and any random gap
    task drive_beat(bir_pkg::in_item_t it);
        int g;
        request <= it;
        start   <= 1'b1;
        do @(negedge clk); while (busy);
        @(posedge clk);
        sb.note_beat(it);
        g = pick_gap();
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // sample request, loading any unwritten window pixels first
    task sample_at(int dx, int dy);
        addr_q_t           q;
        bir_pkg::in_item_t it;
        q = sb.missing(bir_pkg::DEST_W'(dx), bir_pkg::DEST_W'(dy));
        foreach (q[k])
        begin
            if (!sb.written[q[k]])
                drive_beat(pixel_write(q[k] % bir_pkg::MAX_WIDTH, q[k] / bir_pkg::MAX_WIDTH));
        end
        it        = bir_pkg::in_item_t'({$urandom, $urandom, $urandom});
        it.cmd    = bir_pkg::CMD_SAMPLE;
        it.dest_x = bir_pkg::DEST_W'(dx);
        it.dest_y = bir_pkg::DEST_W'(dy);
        drive_beat(it);
    endtask

    // hold off until every predicted pixel is out, then let the block settle
    task drain();
        start <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(negedge clk);
        repeat (200) @(posedge clk);
    endtask

    task apb_write(logic [1:0] idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bir_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_size(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task configure(int unsigned w, int unsigned h, int unsigned ow, int unsigned oh);
        drain();
        apb_write(bir_pkg::REG_SRC_WIDTH, w);
        apb_write(bir_pkg::REG_SRC_HEIGHT, h);
        apb_write(bir_pkg::REG_DST_WIDTH, ow);
        apb_write(bir_pkg::REG_DST_HEIGHT, oh);
    endtask

    // random mix: mostly samples, some stray writes anywhere in the store
    task random_beats(int n, int reach_x, int reach_y);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) < 2)
                drive_beat(pixel_write($urandom_range(0, 255), $urandom_range(0, 255)));
            else if ($urandom_range(0, 9) == 0)
                sample_at($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                sample_at($urandom_range(0, reach_x), $urandom_range(0, reach_y));
        end
    endtask

    initial
    begin
        sb      = new();
        no_gaps = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 4x4 source with extreme pixels, corners and far requests
        configure(4, 4, 8, 8);
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
                drive_beat(pixel_write(x, y));
        end
        drive_beat(pixel_write(255, 255));
        drive_beat(pixel_write(255, 0));
        sample_at(0, 0);
        sample_at(7, 7);
        sample_at(3, 5);
        sample_at(4095, 4095);
        sample_at(8, 0);
        sample_at(1, 6);

        // random phases over several size settings
        random_beats(100, 10, 10);
        configure(1, 1, 1, 1);
        random_beats(40, 3, 3);
        configure(0, 0, 0, 0);
        random_beats(30, 3, 3);
        no_gaps = 1'b1;
        configure(7, 5, 13, 3);
        random_beats(100, 15, 5);
        no_gaps = 1'b0;
        configure(511, 300, 8191, 4096);
        random_beats(60, 100, 60);
        configure(256, 256, 1, 1);
        random_beats(15, 1, 1);
        configure(16, 9, 4096, 4096);
        random_beats(80, 300, 500);
        configure(9, 12, 3, 100);
        random_beats(120, 4, 120);
        for (int p = 0; p < 4; p++)
        begin
            configure($urandom_range(1, 12), $urandom_range(1, 12),
                      $urandom_range(1, 40), $urandom_range(1, 40));
            random_beats(50, 50, 50);
        end

        drain();
        if (sb.errors == 0)
            $display("bicubic_image_resize_tb passed");
        else
            $display("bicubic_image_resize_tb failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("bicubic_image_resize_tb failed");
        $finish;
    end

endmodule
